### rtl/gses_pkg.sv
package gses_pkg;

  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned WidthW    = ColW + 1;
  localparam int unsigned RowW      = 16;
  localparam int unsigned PixW      = 8;
  localparam int unsigned OutColW   = 11;
  localparam int unsigned SideW     = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned GradW     = PixW + 2;
  localparam int unsigned MaxRes    = 3;
  localparam int unsigned OutDepth  = 8;
  localparam int unsigned OutPtrW   = $clog2(OutDepth);
  localparam int unsigned OutCntW   = OutPtrW + 1;

  localparam logic [WidthW-1:0] WidthReset  = WidthW'(640);
  localparam logic [RowW-1:0]   HeightReset = RowW'(480);
  localparam logic [SideW-1:0]  SideReset   = SideW'(6);
  localparam logic [PixW-1:0]   ThreshReset = PixW'(1);

  localparam logic [PixW-1:0] PixMatch   = '0;
  localparam logic [PixW-1:0] PixNoMatch = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1,
    CfgSide   = 2'd2,
    CfgThresh = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [RowW-1:0]    row;
    logic [OutColW-1:0] col;
    logic [PixW-1:0]    pix;
    logic               last;
    logic               eoi;
  } result_t;

  // Bit 0: gy above threshold, bit 1: gy below minus threshold,
  // bit 2: gx above threshold, bit 3: gx below minus threshold.
  function automatic logic [3:0] side_pattern(input logic [SideW-1:0] sel);
    logic [3:0] pat;
    unique case (sel)
      3'd0:    pat = 4'h2;
      3'd1:    pat = 4'h6;
      3'd2:    pat = 4'h4;
      3'd3:    pat = 4'h5;
      3'd4:    pat = 4'h1;
      3'd5:    pat = 4'h9;
      3'd6:    pat = 4'h8;
      default: pat = 4'hA;
    endcase
    return pat;
  endfunction

  function automatic logic [PixW-1:0] classify(input logic signed [GradW-1:0] gx,
                                               input logic signed [GradW-1:0] gy,
                                               input logic [PixW-1:0]         thr,
                                               input logic [SideW-1:0]        sel);
    logic signed [GradW-1:0] pos_t;
    logic signed [GradW-1:0] neg_t;
    logic [3:0]              flags;
    pos_t = $signed({2'b00, thr});
    neg_t = -pos_t;
    flags[0] = gy > pos_t;
    flags[1] = gy < neg_t;
    flags[2] = gx > pos_t;
    flags[3] = gx < neg_t;
    return (flags == side_pattern(sel)) ? PixMatch : PixNoMatch;
  endfunction

endpackage

### rtl/gradient_sign_edge_select_unit.sv
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+-------------------------------------------
// in       | in_valid_i / in_ready_o     | pixel_in_i
// out      | out_valid_o / out_ready_i   | out_row_o, out_col_o, pixel_out_o,
//          |                             | last_of_run_o, end_of_image_o
// cfg      | cfg_we_i                    | cfg_index_i, cfg_data_i
//
// One pixel is accepted per cycle while the result queue has room; the line buffers are
// read at acceptance and written back in the following cycle, with forwarding from that
// write to the next read. Results are registered with their pixel and then pass through
// an eight-entry result queue; on the last row a pixel gives up to three results, so a
// full queue holds the input until the consumer drains it. Reset clears the counters
// and queue and loads the default configuration; the line buffers are not cleared.
module gradient_sign_edge_select_unit
  import gses_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PixW-1:0]     pixel_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [RowW-1:0]     out_row_o,
  output logic [OutColW-1:0]  out_col_o,
  output logic [PixW-1:0]     pixel_out_o,
  output logic                last_of_run_o,
  output logic                end_of_image_o
);

  logic [WidthW-1:0] cfg_width_q;
  logic [RowW-1:0]   cfg_height_q;
  logic [SideW-1:0]  cfg_side_q;
  logic [PixW-1:0]   cfg_thresh_q;

  logic [PixW-1:0] prev_mem  [MaxWidth];
  logic [PixW-1:0] prev2_mem [MaxWidth];

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [PixW-1:0] hist0_q, hist1_q;

  logic            s1_valid_q;
  logic [PixW-1:0] s1_px_q;
  logic [ColW-1:0] s1_col_q;
  logic [RowW-1:0] s1_row_q;
  logic            s1_last_col_q;
  logic            s1_last_row_q;
  logic [PixW-1:0] s1_hist1_q;
  logic [PixW-1:0] prev_c_rd_q;
  logic [PixW-1:0] prev_n_rd_q;
  logic [PixW-1:0] prev2_rd_q;
  logic [PixW-1:0] last_copy_q;

  result_t             fifo_mem [OutDepth];
  logic [OutPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [OutCntW-1:0]  cnt_q, cnt_d;

  logic              in_fire;
  logic              out_fire;
  logic [WidthW-1:0] eff_w;
  logic [RowW-1:0]   eff_h;
  logic              col_wrap;
  logic [RowW:0]     row_pre;
  logic [ColW-1:0]   cur_col;
  logic [ColW-1:0]   cur_col_p1;
  logic [RowW-1:0]   cur_row;
  logic              cur_last_col;
  logic              cur_last_row;

  logic signed [GradW-1:0] gx0, gy0, gx1;
  result_t                 res      [MaxRes];
  logic    [MaxRes-1:0]    res_v;
  result_t                 push_ent [MaxRes];
  logic    [1:0]           push_n;
  logic    [1:0]           push_cnt;
  result_t                 head;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;

  always_comb begin
    if (cfg_width_q == '0) begin
      eff_w = WidthW'(1);
    end else if (cfg_width_q > WidthW'(MaxWidth)) begin
      eff_w = WidthW'(MaxWidth);
    end else begin
      eff_w = cfg_width_q;
    end
    eff_h = (cfg_height_q == '0) ? RowW'(1) : cfg_height_q;

    col_wrap     = {1'b0, col_q} >= eff_w;
    cur_col      = col_wrap ? '0 : col_q;
    cur_col_p1   = cur_col + ColW'(1);
    row_pre      = col_wrap ? ({1'b0, row_q} + (RowW+1)'(1)) : {1'b0, row_q};
    cur_row      = (row_pre >= {1'b0, eff_h}) ? '0 : row_pre[RowW-1:0];
    cur_last_col = ({1'b0, cur_col} + WidthW'(1)) == eff_w;
    cur_last_row = ({1'b0, cur_row} + (RowW+1)'(1)) == {1'b0, eff_h};

    if (cur_last_col) begin
      col_d = '0;
      row_d = cur_last_row ? '0 : cur_row + RowW'(1);
    end else begin
      col_d = cur_col_p1;
      row_d = cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WidthReset;
      cfg_height_q <= HeightReset;
      cfg_side_q   <= SideReset;
      cfg_thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgWidth:  cfg_width_q  <= cfg_data_i[WidthW-1:0];
        CfgHeight: cfg_height_q <= cfg_data_i[RowW-1:0];
        CfgSide:   cfg_side_q   <= cfg_data_i[SideW-1:0];
        CfgThresh: cfg_thresh_q <= cfg_data_i[PixW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      hist0_q    <= '0;
      hist1_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
      if (in_fire) begin
        col_q   <= col_d;
        row_q   <= row_d;
        hist0_q <= pixel_in_i;
        hist1_q <= hist0_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_px_q       <= pixel_in_i;
      s1_col_q      <= cur_col;
      s1_row_q      <= cur_row;
      s1_last_col_q <= cur_last_col;
      s1_last_row_q <= cur_last_row;
      s1_hist1_q    <= hist1_q;
    end
    if (s1_valid_q) begin
      last_copy_q <= prev_c_rd_q;
    end
  end

  // Line buffers: read at acceptance, written back from the following stage.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      prev_mem[s1_col_q]  <= s1_px_q;
      prev2_mem[s1_col_q] <= prev_c_rd_q;
    end
    if (in_fire) begin
      if (s1_valid_q && (s1_col_q == cur_col)) begin
        prev_c_rd_q <= s1_px_q;
        prev2_rd_q  <= prev_c_rd_q;
      end else begin
        prev_c_rd_q <= prev_mem[cur_col];
        prev2_rd_q  <= prev2_mem[cur_col];
      end
      if (s1_valid_q && (s1_col_q == cur_col_p1)) begin
        prev_n_rd_q <= s1_px_q;
      end else begin
        prev_n_rd_q <= prev_mem[cur_col_p1];
      end
    end
  end

  always_comb begin
    if ((s1_col_q == '0) || s1_last_col_q) begin
      gx0 = '0;
    end else begin
      gx0 = $signed({2'b00, prev_n_rd_q}) - $signed({2'b00, last_copy_q});
    end
    if (s1_row_q == RowW'(1)) begin
      gy0 = '0;
    end else begin
      gy0 = $signed({2'b00, s1_px_q}) - $signed({2'b00, prev2_rd_q});
    end
    if (s1_col_q == ColW'(1)) begin
      gx1 = '0;
    end else begin
      gx1 = $signed({2'b00, s1_px_q}) - $signed({2'b00, s1_hist1_q});
    end

    res_v[0] = s1_row_q != '0;
    res_v[1] = s1_last_row_q && (s1_col_q != '0);
    res_v[2] = s1_last_row_q && s1_last_col_q;

    res[0].row  = s1_row_q - RowW'(1);
    res[0].col  = OutColW'(s1_col_q);
    res[0].pix  = classify(gx0, gy0, cfg_thresh_q, cfg_side_q);
    res[0].last = res_v[0] && !res_v[1] && !res_v[2];
    res[0].eoi  = 1'b0;

    res[1].row  = s1_row_q;
    res[1].col  = OutColW'(s1_col_q - ColW'(1));
    res[1].pix  = classify(gx1, '0, cfg_thresh_q, cfg_side_q);
    res[1].last = res_v[1] && !res_v[2];
    res[1].eoi  = 1'b0;

    res[2].row  = s1_row_q;
    res[2].col  = OutColW'(s1_col_q);
    res[2].pix  = classify('0, '0, cfg_thresh_q, cfg_side_q);
    res[2].last = res_v[2];
    res[2].eoi  = 1'b1;

    push_n = '0;
    for (int k = 0; k < MaxRes; k++) begin
      push_ent[k] = '0;
    end
    for (int j = 0; j < MaxRes; j++) begin
      if (res_v[j]) begin
        push_ent[push_n] = res[j];
        push_n = push_n + 2'd1;
      end
    end
    push_cnt = s1_valid_q ? push_n : '0;
  end

  always_comb begin
    cnt_d = cnt_q + OutCntW'(push_cnt) - OutCntW'(out_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + OutPtrW'(push_cnt);
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + OutPtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (2'(k) < push_cnt) begin
        fifo_mem[wr_ptr_q + OutPtrW'(k)] <= push_ent[k];
      end
    end
  end

  assign in_ready_o = (cnt_q + (s1_valid_q ? OutCntW'(MaxRes) : '0))
                      <= OutCntW'(OutDepth - MaxRes);

  assign head           = fifo_mem[rd_ptr_q];
  assign out_valid_o    = cnt_q != '0;
  assign out_row_o      = head.row;
  assign out_col_o      = head.col;
  assign pixel_out_o    = head.pix;
  assign last_of_run_o  = head.last;
  assign end_of_image_o = head.eoi;

endmodule

### tb/sv/tb.sv
module tb;
  import gses_pkg::*;

  localparam int unsigned HalfPeriod  = 6;
  localparam int unsigned LimitCycles = 500000;
  localparam logic [31:0] SideFlags   = {4'hA, 4'h8, 4'h9, 4'h1, 4'h5, 4'h4, 4'h6, 4'h2};

  typedef enum int unsigned {
    PixRandom,
    PixExtreme,
    PixNearThresh
  } pix_style_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [PixW-1:0]     pixel_in_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b1;
  logic [RowW-1:0]     out_row_o;
  logic [OutColW-1:0]  out_col_o;
  logic [PixW-1:0]     pixel_out_o;
  logic                last_of_run_o;
  logic                end_of_image_o;

  gradient_sign_edge_select_unit i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .pixel_in_i,
    .out_valid_o,
    .out_ready_i,
    .out_row_o,
    .out_col_o,
    .pixel_out_o,
    .last_of_run_o,
    .end_of_image_o
  );

  // Local copy of the configuration and of the block's line state.
  bit [11:0]       width_cfg  = 12'd640;
  bit [15:0]       height_cfg = 16'd480;
  bit [2:0]        side_cfg   = 3'd6;
  bit [7:0]        thresh_cfg = 8'd1;
  bit [7:0]        line_prev1 [MaxWidth];
  bit [7:0]        line_prev2 [MaxWidth];
  bit [7:0]        row_hist   [2];
  int unsigned     col_pos;
  int unsigned     row_pos;
  result_t         awaited_edges [$];
  result_t         head_edge;

  int unsigned     in_idle_pct;
  int unsigned     out_stall_pct;
  int unsigned     n_errors;
  int unsigned     n_pixels;
  int unsigned     n_results;
  int unsigned     n_frames;

  always #HalfPeriod clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic int unsigned frame_cols();
    if (width_cfg == 0) return 1;
    if (width_cfg > MaxWidth) return MaxWidth;
    return 32'(width_cfg);
  endfunction

  function automatic int unsigned frame_rows();
    return (height_cfg == 0) ? 1 : 32'(height_cfg);
  endfunction

  function automatic result_t grade_pixel(input int unsigned row, input int unsigned col,
                                          input int gx, input int gy, input bit eoi);
    result_t    res;
    logic [3:0] flags;
    int         t;
    t        = int'(thresh_cfg);
    flags[0] = gy > t;
    flags[1] = gy < -t;
    flags[2] = gx > t;
    flags[3] = gx < -t;
    res.row  = row[15:0];
    res.col  = col[10:0];
    res.pix  = (flags == SideFlags[int'(side_cfg) * 4 +: 4]) ? 8'd0 : 8'd255;
    res.last = 1'b0;
    res.eoi  = eoi;
    return res;
  endfunction

  function automatic void predict_edges(input logic [7:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int          px;
    int          above;
    int          left;
    int          right;
    int          gx;
    int          gy;
    bit          last_col;
    bit          last_row;
    result_t     batch [$];
    w  = frame_cols();
    h  = frame_rows();
    px = int'(pix);
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c        = col_pos;
    r        = row_pos;
    last_col = (c + 1 == w);
    last_row = (r + 1 == h);
    above    = int'(line_prev2[c]);
    right    = last_col ? 0 : int'(line_prev1[c + 1]);
    line_prev2[c] = line_prev1[c];
    line_prev1[c] = pix;
    if (r >= 1) begin
      left = (c == 0) ? 0 : int'(line_prev2[c - 1]);
      gx   = (c == 0 || last_col) ? 0 : right - left;
      gy   = (r == 1) ? 0 : px - above;
      batch.push_back(grade_pixel(r - 1, c, gx, gy, 1'b0));
    end
    if (last_row && c >= 1) begin
      gx = (c == 1) ? 0 : px - int'(row_hist[1]);
      batch.push_back(grade_pixel(r, c - 1, gx, 0, 1'b0));
    end
    if (last_row && last_col) batch.push_back(grade_pixel(r, c, 0, 0, 1'b1));
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) awaited_edges.push_back(batch[i]);
    row_hist[1] = row_hist[0];
    row_hist[0] = pix;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function automatic void report_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (awaited_edges.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual row %0d col %0d pixel %0d",
                 $time, out_row_o, out_col_o, pixel_out_o);
        n_errors++;
      end else begin
        head_edge = awaited_edges.pop_front();
        report_field("row", head_edge.row, out_row_o);
        report_field("col", 16'(head_edge.col), 16'(out_col_o));
        report_field("pixel", 16'(head_edge.pix), 16'(pixel_out_o));
        report_field("last_of_run", 16'(head_edge.last), 16'(last_of_run_o));
        report_field("end_of_image", 16'(head_edge.eoi), 16'(end_of_image_o));
      end
    end
  end

  // The request stays valid with its pixel unchanged until it is taken.
  task automatic push_pixel(input logic [7:0] pix);
    @(negedge clk_i);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (!in_ready_o);
    predict_edges(pix);
    n_pixels++;
  endtask

  task automatic stop_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    stop_input();
    while (awaited_edges.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgWidth:  width_cfg  = val[11:0];
      CfgHeight: height_cfg = val;
      CfgSide:   side_cfg   = val[2:0];
      default:   thresh_cfg = val[7:0];
    endcase
  endtask

  task automatic set_frame(input logic [15:0] cols, input logic [15:0] rows,
                           input logic [15:0] side, input logic [15:0] thresh);
    wait_idle();
    write_reg(CfgWidth, cols);
    write_reg(CfgHeight, rows);
    write_reg(CfgSide, side);
    write_reg(CfgThresh, thresh);
  endtask

  function automatic logic [7:0] pick_pixel(input pix_style_e style);
    int unsigned span;
    span = (thresh_cfg > 150) ? 150 : 32'(thresh_cfg);
    case (style)
      PixExtreme:    return $urandom_range(1) ? 8'hFF : 8'h00;
      PixNearThresh: return 8'(100 + $urandom_range(span + 1));
      default:       return 8'($urandom);
    endcase
  endfunction

  task automatic send_frame(input pix_style_e style);
    int unsigned total;
    total = frame_cols() * frame_rows();
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(99) < 2) wait_idle();
      push_pixel(pick_pixel(style));
    end
    n_frames++;
  endtask

  task automatic test_corner_frames();
    logic [7:0] ridge [9];
    ridge = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    in_idle_pct   = 0;
    out_stall_pct = 0;
    set_frame(3, 3, 0, 0);
    foreach (ridge[i]) push_pixel(ridge[i]);
    n_frames++;
    set_frame(3, 3, 7, 255);
    send_frame(PixExtreme);
    set_frame(0, 0, 3, 0);
    send_frame(PixExtreme);
    set_frame(1, 2, 4, 0);
    send_frame(PixExtreme);
    set_frame(2, 1, 2, 0);
    send_frame(PixExtreme);
  endtask

  task automatic test_wide_lines();
    in_idle_pct   = 0;
    out_stall_pct = 6;
    set_frame(10, 2, 16'($urandom_range(7)), 16'($urandom_range(8)));
    send_frame(PixRandom);
  endtask

  task automatic test_tallest_frame();
    in_idle_pct   = 72;
    out_stall_pct = 72;
    set_frame(3, 65535, 5, 2);
    repeat (9) push_pixel(pick_pixel(PixRandom));
    // Shrinking the height at a row boundary makes the next row the last one.
    wait_idle();
    write_reg(CfgHeight, 16'd4);
    repeat (3) push_pixel(pick_pixel(PixRandom));
    n_frames++;
  endtask

  task automatic test_random_frames(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned quota);
    int unsigned sent;
    logic [15:0] cols;
    logic [15:0] rows;
    logic [15:0] thresh;
    sent = 0;
    while (sent < quota) begin
      cols   = ($urandom_range(99) < 80) ? 16'($urandom_range(3, 7)) : 16'($urandom_range(2));
      rows   = ($urandom_range(99) < 80) ? 16'($urandom_range(2, 5)) : 16'($urandom_range(1));
      thresh = ($urandom_range(99) < 60) ? 16'($urandom_range(8)) : 16'($urandom_range(255));
      set_frame(cols, rows, 16'($urandom_range(7)), thresh);
      in_idle_pct   = idle_pct;
      out_stall_pct = stall_pct;
      send_frame(pix_style_e'($urandom_range(2)));
      sent += frame_cols() * frame_rows();
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_corner_frames();
    test_wide_lines();
    test_tallest_frame();
    test_random_frames(0, 0, 10);
    test_random_frames(72, 0, 10);
    test_random_frames(0, 72, 10);
    test_random_frames(6, 6, 10);
    wait_idle();
    repeat (16) @(posedge clk_i);
    $display("Sent %0d pixels in %0d frames and checked %0d results, %0d mismatches.",
             n_pixels, n_frames, n_results, n_errors);
    $display("Frames ranged from a single pixel to ten columns, with a cut-short frame of"
             , " 65535 rows, on all sides.");
    if (n_errors == 0 && awaited_edges.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(LimitCycles * 2 * HalfPeriod);
    $display("%0t: timed out with %0d results outstanding", $time, awaited_edges.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
rtl/gses_pkg.sv
rtl/gradient_sign_edge_select_unit.sv
tb/sv/tb.sv
